/* rtl/mcls_pkg.sv */
// Shared types, constants and the Morse code table for the LED segment encoder.
`timescale 1ns / 1ps

package mcls_pkg;

  // Stream widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned MAX_ELEM = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_DOT_ON     = 2'd0;
  localparam logic [1:0] CFG_DASH_ON    = 2'd1;
  localparam logic [1:0] CFG_ELEM_GAP   = 2'd2;
  localparam logic [1:0] CFG_LETTER_GAP = 2'd3;

  // Reset values in milliseconds
  localparam logic [DUR_W-1:0] DOT_ON_RST     = 16'd200;
  localparam logic [DUR_W-1:0] DASH_ON_RST    = 16'd800;
  localparam logic [DUR_W-1:0] ELEM_GAP_RST   = 16'd400;
  localparam logic [DUR_W-1:0] LETTER_GAP_RST = 16'd600;

  // One encoded character: element count and dash flags, first element in bit 0
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [MAX_ELEM-1:0] dash;
  } mcls_code_t;

  typedef struct packed {
    logic       known;
    mcls_code_t code;
  } mcls_class_t;

  // Segment timing registers
  typedef struct packed {
    logic [DUR_W-1:0] dot_on;
    logic [DUR_W-1:0] dash_on;
    logic [DUR_W-1:0] elem_gap;
    logic [DUR_W-1:0] letter_gap;
  } mcls_cfg_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ON,
    BK_GAP,
    BK_END
  } mcls_back_state_t;

  function automatic mcls_class_t mk(input logic [LEN_W-1:0] len,
                                     input logic [MAX_ELEM-1:0] dash);
    mcls_class_t r;
    r.known     = 1'b1;
    r.code.len  = len;
    r.code.dash = dash;
    return r;
  endfunction

  // Classify an ASCII code; unknown codes come back with known clear
  function automatic mcls_class_t classify(input logic [CHAR_W-1:0] c);
    mcls_class_t r;
    r = '0;
    case (c)
      8'h20: r = mk(3'd0, 5'b00000); // space
      8'h61: r = mk(3'd2, 5'b00010); // a
      8'h62: r = mk(3'd4, 5'b00001); // b
      8'h63: r = mk(3'd4, 5'b00101); // c
      8'h64: r = mk(3'd3, 5'b00001); // d
      8'h65: r = mk(3'd1, 5'b00000); // e
      8'h66: r = mk(3'd4, 5'b00100); // f
      8'h67: r = mk(3'd3, 5'b00011); // g
      8'h68: r = mk(3'd4, 5'b00000); // h
      8'h69: r = mk(3'd2, 5'b00000); // i
      8'h6a: r = mk(3'd4, 5'b01110); // j
      8'h6b: r = mk(3'd3, 5'b00101); // k
      8'h6c: r = mk(3'd4, 5'b00010); // l
      8'h6d: r = mk(3'd2, 5'b00011); // m
      8'h6e: r = mk(3'd2, 5'b00001); // n
      8'h6f: r = mk(3'd3, 5'b00111); // o
      8'h70: r = mk(3'd4, 5'b00110); // p
      8'h71: r = mk(3'd4, 5'b01011); // q
      8'h72: r = mk(3'd3, 5'b00010); // r
      8'h73: r = mk(3'd3, 5'b00000); // s
      8'h74: r = mk(3'd1, 5'b00001); // t
      8'h75: r = mk(3'd3, 5'b00100); // u
      8'h76: r = mk(3'd4, 5'b01000); // v
      8'h77: r = mk(3'd3, 5'b00110); // w
      8'h78: r = mk(3'd4, 5'b01001); // x
      8'h79: r = mk(3'd4, 5'b01101); // y
      8'h7a: r = mk(3'd4, 5'b00011); // z
      8'h30: r = mk(3'd5, 5'b11111); // 0
      8'h31: r = mk(3'd5, 5'b11110); // 1
      8'h32: r = mk(3'd5, 5'b11100); // 2
      8'h33: r = mk(3'd5, 5'b11000); // 3
      8'h34: r = mk(3'd5, 5'b10000); // 4
      8'h35: r = mk(3'd5, 5'b00000); // 5
      8'h36: r = mk(3'd5, 5'b00001); // 6
      8'h37: r = mk(3'd5, 5'b00011); // 7
      8'h38: r = mk(3'd5, 5'b00111); // 8
      8'h39: r = mk(3'd5, 5'b01111); // 9
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/morse_char_to_led_segments_unit.sv */
// Top level of the Morse character to LED segment encoder.
// Usage:
//   Input stream (s_*): one ASCII character per request in s_tdata. Lower-case
//   a-z, 0-9 and space are encoded; any other code is taken and dropped.
//   Output stream (m_*): one LED segment per request, level in tdata bit 0 and
//   duration in ms in tdata bits 16:1; tlast marks the closing letter gap.
//   A dot or dash gives an on segment and an element gap; every character
//   ends with a letter gap segment; a space gives only that gap.
//   Configuration port: cfg_we with cfg_index 0..3 writes dot on, dash on,
//   element gap and letter gap times. Write only while the block is idle.
// Path: an accepted character passes the front register, the queue and the back
//   end sequencer before its first segment shows in the output register.
// Throughput: the back end sequencer issues one segment per cycle while the
//   output is not stalled, at most 11 segments per character, plus a queue pop
//   per character; the queue lets new characters in while one is being sent.
// Reset: rst clears the queue, the sequencer and the output valid, and loads
//   the timing registers with 200, 800, 400 and 600 ms.
// Stalls: a held m_tready freezes the output register and the segment states;
//   the front keeps taking characters until the queue and its register are full.
`timescale 1ns / 1ps

module morse_char_to_led_segments_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mcls_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mcls_pkg::OUT_W-1:0] m_tdata,    // [0] led_level, [16:1] duration_ms
  output logic                       m_tlast,    // last_segment
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mcls_pkg::DUR_W-1:0] cfg_data
);
  import mcls_pkg::*;

  mcls_cfg_t  cfg;
  logic       push;
  mcls_code_t push_code;
  logic       q_ready;
  logic       q_pop;
  logic       q_not_empty;
  mcls_code_t q_head;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_on     <= DOT_ON_RST;
      cfg.dash_on    <= DASH_ON_RST;
      cfg.elem_gap   <= ELEM_GAP_RST;
      cfg.letter_gap <= LETTER_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOT_ON:     cfg.dot_on     <= cfg_data;
        CFG_DASH_ON:    cfg.dash_on    <= cfg_data;
        CFG_ELEM_GAP:   cfg.elem_gap   <= cfg_data;
        CFG_LETTER_GAP: cfg.letter_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  mcls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_code (push_code),
    .q_ready   (q_ready)
  );

  mcls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_code (push_code),
    .ready     (q_ready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mcls_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

/* rtl/mcls_front.sv */
// Front end: accepts characters, looks up their Morse code, drops unknown codes.
`timescale 1ns / 1ps

module mcls_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mcls_pkg::CHAR_W-1:0] s_tdata,
  output logic                       push,
  output mcls_pkg::mcls_code_t       push_code,
  input  logic                       q_ready
);
  import mcls_pkg::*;

  logic        fv;
  mcls_code_t  fcode;
  mcls_class_t cls;
  logic        take;

  assign cls       = classify(s_tdata);
  assign push      = fv && q_ready;
  assign push_code = fcode;
  assign s_tready  = !fv || q_ready;
  assign take      = s_tvalid && s_tready;

  // Classified request register
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= cls.known;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fcode <= cls.code;
    end
  end

endmodule

/* rtl/mcls_queue.sv */
// Short FIFO of classified codes between front and back end.
`timescale 1ns / 1ps

module mcls_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mcls_pkg::mcls_code_t push_code,
  output logic                 ready,
  input  logic                 pop,
  output logic                 not_empty,
  output mcls_pkg::mcls_code_t head
);
  import mcls_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mcls_code_t      mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign ready     = (count != FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && ready;
  assign do_pop    = pop && not_empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_code;
    end
  end

endmodule

/* rtl/mcls_back.sv */
// Back end: walks one code per request and emits LED segments into the output register.
`timescale 1ns / 1ps

module mcls_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mcls_pkg::mcls_cfg_t        cfg,
  input  logic                       q_not_empty,
  input  mcls_pkg::mcls_code_t       q_head,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mcls_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import mcls_pkg::*;

  mcls_back_state_t     state, state_next;
  logic [LEN_W-1:0]     len;
  logic [MAX_ELEM-1:0]  dash;
  logic [LEN_W-1:0]     idx, idx_next;
  logic                 out_free;
  logic                 emit;
  logic                 seg_level;
  logic [DUR_W-1:0]     seg_dur;
  logic                 seg_last;

  assign out_free = !m_tvalid || m_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Current code, taken from the queue head on pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      len  <= q_head.len;
      dash <= q_head.dash;
    end
  end

  // Next state and segment selection
  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    emit       = 1'b0;
    seg_level  = 1'b0;
    seg_dur    = cfg.letter_gap;
    seg_last   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_pop      = 1'b1;
          idx_next   = '0;
          state_next = (q_head.len == '0) ? BK_END : BK_ON;
        end
      end
      BK_ON: begin
        seg_level = 1'b1;
        seg_dur   = dash[idx] ? cfg.dash_on : cfg.dot_on;
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_GAP;
        end
      end
      BK_GAP: begin
        seg_dur = cfg.elem_gap;
        if (out_free) begin
          emit       = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = (idx + 1'b1 == len) ? BK_END : BK_ON;
        end
      end
      BK_END: begin
        seg_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {(OUT_W - DUR_W - 1)'(0), seg_dur, seg_level};
      m_tlast <= seg_last;
    end
  end

endmodule

/* rtl/mcls_checker.sv */
// Port-level checks on the encoder output stream, bound to the top level.
`timescale 1ns / 1ps

module mcls_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [mcls_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import mcls_pkg::*;

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Nothing valid right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Run end is always an off segment
  a_last_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[0])
    else $error("last segment is not off");

  // Every on segment is followed at once by an element gap
  a_on_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[0] |=> m_tvalid && !m_tdata[0] && !m_tlast)
    else $error("on segment not followed by element gap");

endmodule

bind morse_char_to_led_segments_unit mcls_checker u_mcls_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* tb/tb_morse_char_to_led_segments_unit.sv */
// Self-checking stream testbench for the Morse character to LED segment encoder.
`timescale 1ns / 1ps

module tb_morse_char_to_led_segments_unit;
  import mcls_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_CHARS   = 68;

  // One LED segment as seen on the output stream
  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
    logic             last;
  } led_seg_t;

  // Keeps the timing registers, expands characters into segments, checks output
  class segment_board;
    led_seg_t         pending[$];
    int               fault_count;
    logic [DUR_W-1:0] dot_ms;
    logic [DUR_W-1:0] dash_ms;
    logic [DUR_W-1:0] elem_gap_ms;
    logic [DUR_W-1:0] letter_gap_ms;
    string letters[26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                           ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                           "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
    string digits[10]  = '{"-----", ".----", "..---", "...--", "....-",
                           ".....", "-....", "--...", "---..", "----."};

    function new();
      fault_count   = 0;
      dot_ms        = DOT_ON_RST;
      dash_ms       = DASH_ON_RST;
      elem_gap_ms   = ELEM_GAP_RST;
      letter_gap_ms = LETTER_GAP_RST;
    endfunction

    function void load_timing(input logic [1:0] idx, input logic [DUR_W-1:0] val);
      case (idx)
        CFG_DOT_ON:     dot_ms        = val;
        CFG_DASH_ON:    dash_ms       = val;
        CFG_ELEM_GAP:   elem_gap_ms   = val;
        CFG_LETTER_GAP: letter_gap_ms = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Expand one accepted character into its expected segments
    function void take_char(input logic [CHAR_W-1:0] c);
      string pattern;
      if (c >= "a" && c <= "z") begin
        pattern = letters[c - "a"];
      end else if (c >= "0" && c <= "9") begin
        pattern = digits[c - "0"];
      end else if (c == " ") begin
        pattern = "";
      end else begin
        return;   // unknown codes are dropped
      end
      for (int k = 0; k < pattern.len(); k++) begin
        pending.push_back('{1'b1, (pattern[k] == "-") ? dash_ms : dot_ms, 1'b0});
        pending.push_back('{1'b0, elem_gap_ms, 1'b0});
      end
      pending.push_back('{1'b0, letter_gap_ms, 1'b1});
    endfunction

    // Compare one accepted segment with the oldest expected one
    function void match_segment(input logic level, input logic [DUR_W-1:0] dur,
                                input logic last);
      led_seg_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected segment level=%0b dur=%0d last=%0b",
                 $time, level, dur, last);
        fault_count++;
        return;
      end
      want = pending.pop_front();
      if (want.level !== level) begin
        $display("%0t: led_level expected %0b actual %0b", $time, want.level, level);
        fault_count++;
      end
      if (want.dur !== dur) begin
        $display("%0t: duration_ms expected %0d actual %0d", $time, want.dur, dur);
        fault_count++;
      end
      if (want.last !== last) begin
        $display("%0t: last_segment expected %0b actual %0b", $time, want.last, last);
        fault_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [DUR_W-1:0]  cfg_data;

  segment_board board;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           cycle_count;

  morse_char_to_led_segments_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Requests on both streams, sampled at the edge that takes them
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.take_char(s_tdata);
      if (m_tvalid && m_tready) board.match_segment(m_tdata[0], m_tdata[DUR_W:1], m_tlast);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d segments still expected", $time, board.outstanding());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one character, with a random gap ahead of it
  task automatic send_char(input logic [CHAR_W-1:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold off until every expected segment is out, then let the block go quiet
  task automatic settle_block();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four timing registers back to back
  task automatic write_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                              input logic [DUR_W-1:0] egap, input logic [DUR_W-1:0] lgap);
    logic [1:0]       idx_list [4];
    logic [DUR_W-1:0] val_list [4];
    idx_list = '{CFG_DOT_ON, CFG_DASH_ON, CFG_ELEM_GAP, CFG_LETTER_GAP};
    val_list = '{dot, dash, egap, lgap};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      board.load_timing(idx_list[i], val_list[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly recognised characters, the rest any byte
  function automatic logic [CHAR_W-1:0] pick_char();
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyz0123456789 ";
    if ($urandom_range(99) < 80) return alphabet[$urandom_range(alphabet.len() - 1)];
    return CHAR_W'($urandom_range(255));
  endfunction

  initial begin
    logic [CHAR_W-1:0] directed [];
    directed      = '{" ", "e", "t", "a", "n", "z", "q", "y", "0", "1",
                      "4", "5", "6", "9", "A", 8'h00, 8'hFF, 8'h2F,
                      8'h3A, 8'h60, 8'h7B, 8'h1F, 8'h21, "s", "o"};
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DOT_ON;
    cfg_data      = '0;
    rst           = 1'b1;
    cycle_count   = 0;
    send_idle_pct = 16;
    recv_idle_pct = 88;
    board         = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: edges of the code space, unknown codes, longest runs, reset timing
    foreach (directed[i]) send_char(directed[i]);
    settle_block();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 88;
      end else if (phase < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: ;   // keep reset timing
        1: write_timing('0, '0, '0, '0);
        2: write_timing('1, '1, '1, '1);
        4: write_timing('0, '1, 16'd1, 16'hFFFE);
        default: write_timing(DUR_W'($urandom_range(65535)), DUR_W'($urandom_range(65535)),
                              DUR_W'($urandom_range(65535)), DUR_W'($urandom_range(65535)));
      endcase
      for (int n = 0; n < PHASE_CHARS; n++) begin
        if ($urandom_range(39) == 0) settle_block();
        send_char(pick_char());
      end
      settle_block();
    end

    if (board.fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
